>>> design/assert_macros.svh
// Assertion macros shared by the echo delay RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: clock and active-low reset given explicitly.
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// House form: the clock and reset are taken to be clk_i and rst_ni.
`define ASSERT_CLK(lbl, prop, msg) `ASSERT_IMPL(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> design/vsed_pkg.sv
// Shared types and constants for the variable speed echo delay.
// Used by the pointer unit and the top level; depends on nothing.
package vsed_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int GAIN_W     = 16;
  localparam int STEP_W     = 24;
  localparam int TGT_W      = 17;
  localparam int DIST_W     = 16;
  localparam int FRAC_W     = 16;
  localparam int FB_SHIFT   = 15;
  localparam int MIX_SHIFT  = 14;
  localparam int SAMPLE_MAX = 8388607;
  localparam int SAMPLE_MIN = -8388608;

  typedef enum logic {
    CMD_AUDIO = 1'b0,
    CMD_FORCE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_FEEDBACK_GAIN = 2'd0,
    REG_MIX_GAIN      = 2'd1,
    REG_READ_STEP     = 2'd2,
    REG_TARGET_DELAY  = 2'd3
  } reg_idx_e;

  // Per-transfer request from the top level to the pointer unit.
  typedef struct packed {
    logic              advance;
    logic              force_en;
    logic [DIST_W-1:0] distance;
  } ptr_req_t;

endpackage

>>> design/vsed_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing; read during write at the same address returns old data.
module vsed_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/vsed_ptr.sv
// Write index, fractional read position and fill count of the echo store.
// Depends on vsed_pkg and assert_macros.svh.
`include "assert_macros.svh"
module vsed_ptr
  import vsed_pkg::*;
#(
  parameter int DELAY_DEPTH = 65536
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ptr_req_t                       req_i,
  input  logic [STEP_W-1:0]              step_i,
  input  logic signed [TGT_W-1:0]        target_i,
  output logic [$clog2(DELAY_DEPTH)-1:0] raddr_o,
  output logic [$clog2(DELAY_DEPTH)-1:0] waddr_o,
  output logic                           written_o
);

  localparam int AW   = $clog2(DELAY_DEPTH);
  localparam int PW   = AW + FRAC_W;
  localparam int XW   = (AW + 18 > STEP_W + 2) ? AW + 18 : STEP_W + 2;
  localparam int HALF = DELAY_DEPTH / 2;

  localparam logic signed [XW-1:0] SPAN_X  = XW'(DELAY_DEPTH) <<< FRAC_W;
  localparam logic signed [XW-1:0] MAXD_X  = XW'(DELAY_DEPTH - 1);
  localparam logic signed [XW-1:0] MAXD_FX = MAXD_X <<< FRAC_W;

  logic [AW-1:0] widx_q, widx_d, widx_nx;
  logic [PW-1:0] rpos_q, rpos_d;
  logic [AW:0]   fill_q, fill_d;
  logic [AW-1:0] offset;

  logic signed [XW-1:0] rpos_x, wpos_x, wcur_x, step_x;
  logic signed [XW-1:0] r_a, r_b, r_c, r_d, r_e;
  logic signed [XW-1:0] dist_x, len_x, tgt_x, tgt_c;
  logic signed [XW-1:0] fdist_x, fdist_c, r_f, r_g;

  assign widx_nx = (widx_q == AW'(DELAY_DEPTH - 1)) ? '0 : widx_q + 1'b1;

  assign rpos_x = signed'(XW'(rpos_q));
  assign wpos_x = signed'(XW'({widx_nx, {FRAC_W{1'b0}}}));
  assign wcur_x = signed'(XW'({widx_q, {FRAC_W{1'b0}}}));
  assign step_x = signed'(XW'(step_i));
  assign tgt_x  = XW'(target_i);

  // Audio sample: move the read position and clamp it against the new write
  // position. The lag is measured once, before the target delay is applied.
  always_comb begin
    r_a    = (rpos_x >= wpos_x) ? rpos_x - SPAN_X : rpos_x;
    r_b    = r_a + step_x;
    r_c    = (r_b > wpos_x) ? wpos_x : r_b;
    dist_x = wpos_x - r_c;
    len_x  = dist_x >>> FRAC_W;
    tgt_c  = (tgt_x > MAXD_X) ? MAXD_X : tgt_x;
    r_d    = r_c;
    if (!target_i[TGT_W-1] && (len_x < tgt_c)) begin
      r_d = wpos_x - (tgt_c <<< FRAC_W);
    end
    if (len_x > MAXD_X) begin
      r_d = wpos_x - MAXD_FX;
    end
    r_e = (r_d < 0) ? r_d + SPAN_X : r_d;
  end

  // Force command: whole-sample distance behind the current write index.
  always_comb begin
    fdist_x = signed'(XW'(req_i.distance));
    fdist_c = (fdist_x > MAXD_X) ? MAXD_X : fdist_x;
    r_f     = wcur_x - (fdist_c <<< FRAC_W);
    r_g     = (r_f < 0) ? r_f + SPAN_X : r_f;
  end

  always_comb begin
    widx_d = widx_q;
    rpos_d = rpos_q;
    fill_d = fill_q;
    if (req_i.advance) begin
      widx_d = widx_nx;
      rpos_d = r_e[PW-1:0];
      if (fill_q != (AW+1)'(DELAY_DEPTH)) begin
        fill_d = fill_q + 1'b1;
      end
    end else if (req_i.force_en) begin
      rpos_d = r_g[PW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q <= AW'(HALF);
      rpos_q <= '0;
      fill_q <= '0;
    end else begin
      widx_q <= widx_d;
      rpos_q <= rpos_d;
      fill_q <= fill_d;
    end
  end

  // Writes start at the middle of the store and run upwards, so an entry has
  // been written once its distance from that start is below the fill count.
  assign raddr_o = rpos_q[PW-1:FRAC_W];
  assign waddr_o = widx_q;
  assign offset  = (raddr_o >= AW'(HALF)) ? raddr_o - AW'(HALF)
                                          : raddr_o + AW'(DELAY_DEPTH - HALF);
  assign written_o = ({1'b0, offset} < fill_q);

  `ASSERT_CLK(a_widx_range, widx_q <= AW'(DELAY_DEPTH - 1), "write index out of range")
  `ASSERT_CLK(a_rpos_range, rpos_q[PW-1:FRAC_W] <= AW'(DELAY_DEPTH - 1), "read position out of range")
  `ASSERT_CLK(a_fill_range, fill_q <= (AW+1)'(DELAY_DEPTH), "fill count beyond store depth")

endmodule

>>> design/variable_speed_echo_delay.sv
// Top level of the variable speed echo delay: register port, sample pipeline.
// Depends on vsed_pkg, vsed_ptr, vsed_ram and assert_macros.svh.
//
//  port group      direction  transfer when
//  in (cmd etc.)   input      in_valid_i & in_ready_o
//  out (wet_out)   output     out_valid_o & out_ready_i
//  apb             input      psel & penable & pwrite (pready tied high)
//
// One item is taken every cycle while in_ready_o is high; an audio sample's
// result passes through the stage that holds the registered read of the
// delay store, then the output register. A force command produces no result.
// Reset clears control state only; the store is not swept, a fill count marks
// which entries have been written, so items are taken from the first cycle.
// in_ready_o drops only while the stage after the store read is held by a
// stalled output register.
`include "assert_macros.svh"
module variable_speed_echo_delay
  import vsed_pkg::*;
#(
  parameter int DELAY_DEPTH = 65536
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       cmd_i,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic [DIST_W-1:0]          force_distance_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] wet_out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int AW     = $clog2(DELAY_DEPTH);
  localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
  localparam int ACC_W  = PROD_W + 1;

  localparam logic signed [ACC_W-1:0] FB_HALF  = ACC_W'(1) <<< (FB_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] MIX_HALF = ACC_W'(1) <<< (MIX_SHIFT - 1);

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [SAMPLE_W-1:0] r;
    if (v > ACC_W'(SAMPLE_MAX)) begin
      r = SAMPLE_W'(SAMPLE_MAX);
    end else if (v < ACC_W'(SAMPLE_MIN)) begin
      r = SAMPLE_W'(SAMPLE_MIN);
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [GAIN_W-1:0]       fb_gain_q, mix_gain_q;
  logic [STEP_W-1:0]       step_q;
  logic signed [TGT_W-1:0] target_q;
  logic                    cfg_wr;

  // Sample pipeline.
  logic                       in_xfer, audio_xfer, s1_adv;
  logic                       s1_valid_q, fwd_q, out_valid_q;
  logic signed [SAMPLE_W-1:0] s1_sample_q, fwd_data_q, wet_q;
  logic [AW-1:0]              s1_widx_q;
  logic                       s1_written_q;
  ptr_req_t                   ptr_req;
  logic [AW-1:0]              raddr, waddr;
  logic                       written;
  logic [SAMPLE_W-1:0]        ram_rdata;
  logic signed [SAMPLE_W-1:0] rd;
  logic signed [PROD_W-1:0]   fb_prod, mix_prod;
  logic signed [ACC_W-1:0]    fb_acc, mix_acc;
  logic signed [SAMPLE_W-1:0] fb_sum, mix_sat;

  // APB register port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_gain_q  <= GAIN_W'(16384);
      mix_gain_q <= GAIN_W'(16384);
      step_q     <= STEP_W'(65536);
      target_q   <= '1;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_FEEDBACK_GAIN: fb_gain_q  <= pwdata[GAIN_W-1:0];
        REG_MIX_GAIN:      mix_gain_q <= pwdata[GAIN_W-1:0];
        REG_READ_STEP:     step_q     <= pwdata[STEP_W-1:0];
        REG_TARGET_DELAY:  target_q   <= pwdata[TGT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_FEEDBACK_GAIN: prdata = 32'(fb_gain_q);
      REG_MIX_GAIN:      prdata = 32'(mix_gain_q);
      REG_READ_STEP:     prdata = 32'(step_q);
      REG_TARGET_DELAY:  prdata = 32'(target_q);
    endcase
  end

  // Input side.
  assign s1_adv     = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | s1_adv;
  assign in_xfer    = in_valid_i & in_ready_o;
  assign audio_xfer = in_xfer & (cmd_e'(cmd_i) == CMD_AUDIO);

  assign ptr_req.advance  = audio_xfer;
  assign ptr_req.force_en = in_xfer & (cmd_e'(cmd_i) == CMD_FORCE);
  assign ptr_req.distance = force_distance_i;

  vsed_ptr #(
    .DELAY_DEPTH(DELAY_DEPTH)
  ) u_ptr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ptr_req),
    .step_i    (step_q),
    .target_i  (target_q),
    .raddr_o   (raddr),
    .waddr_o   (waddr),
    .written_o (written)
  );

  vsed_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(DELAY_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_widx_q),
    .wdata_i (fb_sum),
    .re_i    (audio_xfer),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // The store returns old data when the previous sample writes the entry
  // being read in the same cycle, so that value is passed on directly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= audio_xfer;
        fwd_q      <= audio_xfer & s1_valid_q & (raddr == s1_widx_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (audio_xfer) begin
      s1_sample_q  <= sample_in_i;
      s1_widx_q    <= waddr;
      s1_written_q <= written;
      fwd_data_q   <= fb_sum;
    end
  end

  // Feedback and wet arithmetic on the sample read from the store.
  always_comb begin
    if (fwd_q) begin
      rd = fwd_data_q;
    end else if (s1_written_q) begin
      rd = signed'(ram_rdata);
    end else begin
      rd = '0;
    end
    fb_prod  = rd * signed'({1'b0, fb_gain_q});
    mix_prod = rd * signed'({1'b0, mix_gain_q});
    fb_acc   = (ACC_W'(s1_sample_q) <<< FB_SHIFT) + ACC_W'(fb_prod) + FB_HALF;
    mix_acc  = ACC_W'(mix_prod) + MIX_HALF;
    fb_sum   = sat_sample(fb_acc >>> FB_SHIFT);
    mix_sat  = sat_sample(mix_acc >>> MIX_SHIFT);
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      wet_q <= mix_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign wet_out_o   = wet_q;

  `ASSERT_CLK(a_xfer_frees_s1, (audio_xfer && s1_valid_q) |-> s1_adv, "sample taken while stage is held")
  `ASSERT_CLK(a_fwd_live, fwd_q |-> s1_valid_q, "forwarded value without a sample in the stage")
  `ASSERT_CLK(a_out_from_s1, $rose(out_valid_q) |-> $past(s1_valid_q), "result without a sample behind it")

endmodule

>>> test/tb.sv
// Self-checking testbench for variable_speed_echo_delay: directed corner cases, then random
// audio samples and force commands under varying register settings and handshake idling.
// Depends on vsed_pkg and the RTL of the echo delay; it reads no files.
module tb;
  import vsed_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     DEPTH       = 65536;
  localparam longint ONE         = 64'sd65536;
  localparam longint SPAN        = longint'(DEPTH) * ONE;
  localparam int     CYCLE_LIMIT = 300000;
  localparam int     SETTLE      = 8;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic                       cmd_i;
  logic signed [SAMPLE_W-1:0] sample_in_i;
  logic [DIST_W-1:0]          force_distance_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [SAMPLE_W-1:0] wet_out_o;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [3:0]                 paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  // Predicted state of the echo line and its registers.
  logic signed [SAMPLE_W-1:0] echo_mem [DEPTH];
  int unsigned                wr_idx = DEPTH / 2;
  longint                     rd_pos = 0;
  logic [GAIN_W-1:0]          fb_gain = 16'd16384;
  logic [GAIN_W-1:0]          mix_gain = 16'd16384;
  logic [STEP_W-1:0]          rd_step = 24'd65536;
  logic signed [TGT_W-1:0]    tgt_reg = -17'sd1;

  logic signed [SAMPLE_W-1:0] wet_expected [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_left = 0;
  int cycle_count = 0;
  int fail_count = 0;
  int items_sent = 0;
  int forces_sent = 0;
  int wet_checked = 0;
  int settings_written = 0;

  variable_speed_echo_delay #(
    .DELAY_DEPTH(DEPTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .sample_in_i     (sample_in_i),
    .force_distance_i(force_distance_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .wet_out_o       (wet_out_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random back-pressure, or a counted hold-off when one is requested.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    logic signed [SAMPLE_W-1:0] wet_want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (wet_expected.size() == 0) begin
        $error("wet_out: no result expected, got %0d", wet_out_o);
        fail_count++;
      end else begin
        wet_want = wet_expected.pop_front();
        wet_checked++;
        if (wet_out_o !== wet_want) begin
          $error("wet_out: expected %0d, got %0d", wet_want, wet_out_o);
          fail_count++;
        end
      end
    end
  end

  // Rounds half up, shifts down (floor) and saturates to the sample range.
  function automatic logic signed [SAMPLE_W-1:0] sat_round(input longint num, input int sh);
    longint r;
    r = (num + (64'sd1 << (sh - 1))) >>> sh;
    if (r > SAMPLE_MAX) r = SAMPLE_MAX;
    if (r < SAMPLE_MIN) r = SAMPLE_MIN;
    return r[SAMPLE_W-1:0];
  endfunction

  function automatic longint wrap_pos(input longint p);
    if (p >= SPAN) p -= SPAN;
    if (p < 0) p += SPAN;
    return p;
  endfunction

  // Advances the predicted echo line by one item; returns 1 when a wet sample results.
  function automatic bit echo_predict(input cmd_e cmd, input logic signed [SAMPLE_W-1:0] smp,
                                      input logic [DIST_W-1:0] fdist,
                                      output logic signed [SAMPLE_W-1:0] wet);
    longint ridx, wpos, r, len, hold;
    logic signed [SAMPLE_W-1:0] rd;
    wet = '0;
    if (cmd == CMD_FORCE) begin
      // The distance field cannot exceed the store length minus one.
      rd_pos = wrap_pos((longint'(wr_idx) - longint'(fdist)) * ONE);
      return 1'b0;
    end
    ridx = rd_pos >>> FRAC_W;
    if (ridx >= DEPTH) ridx = 0;
    rd = echo_mem[ridx];
    echo_mem[wr_idx] = sat_round(longint'(smp) * 32768 + longint'(rd) * longint'(fb_gain),
                                 FB_SHIFT);
    wr_idx++;
    if (wr_idx >= DEPTH) wr_idx = 0;
    wpos = longint'(wr_idx) * ONE;
    r = rd_pos;
    if (!(r < wpos)) r -= SPAN;
    r += longint'(rd_step);
    if (r > wpos) r = wpos;
    // The length is taken once, before the target and the too-long clamps.
    len = (wpos - r) >>> FRAC_W;
    if (tgt_reg >= 0) begin
      hold = longint'(tgt_reg);
      if (hold > DEPTH - 1) hold = DEPTH - 1;
      if (len < hold) r = wpos - hold * ONE;
    end
    if (len > DEPTH - 1) r = wpos - longint'(DEPTH - 1) * ONE;
    rd_pos = wrap_pos(r);
    wet = sat_round(longint'(rd) * longint'(mix_gain), MIX_SHIFT);
    return 1'b1;
  endfunction

  task automatic send_echo_item(input cmd_e cmd, input logic signed [SAMPLE_W-1:0] smp,
                                input logic [DIST_W-1:0] fdist);
    bit has_wet;
    logic signed [SAMPLE_W-1:0] wet;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    cmd_i            <= cmd;
    sample_in_i      <= smp;
    force_distance_i <= fdist;
    do @(posedge clk_i); while (!in_ready_o);
    has_wet = echo_predict(cmd, smp, fdist, wet);
    if (has_wet) wet_expected.push_back(wet);
    items_sent++;
    if (cmd == CMD_FORCE) forces_sent++;
  endtask

  task automatic send_audio(input logic signed [SAMPLE_W-1:0] smp);
    send_echo_item(CMD_AUDIO, smp, DIST_W'($urandom_range(16'hFFFF)));
  endtask

  task automatic send_force(input logic [DIST_W-1:0] fdist);
    send_echo_item(CMD_FORCE, 24'($urandom), fdist);
  endtask

  // Waits until every expected result has left, then lets a force command settle.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (wet_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FEEDBACK_GAIN: fb_gain  = data[GAIN_W-1:0];
      REG_MIX_GAIN:      mix_gain = data[GAIN_W-1:0];
      REG_READ_STEP:     rd_step  = data[STEP_W-1:0];
      REG_TARGET_DELAY:  tgt_reg  = data[TGT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int fb, input int mx, input int stp, input int tg);
    cfg_write(REG_FEEDBACK_GAIN, fb);
    cfg_write(REG_MIX_GAIN, mx);
    cfg_write(REG_READ_STEP, stp);
    cfg_write(REG_TARGET_DELAY, tg);
    settings_written++;
  endtask

  task automatic apply_random_settings();
    int fb, mx, stp, tg;
    case ($urandom_range(3))
      0:       fb = 0;
      1:       fb = 16'hFFFF;
      2:       fb = $urandom_range(16384, 32767);
      default: fb = $urandom_range(16'hFFFF);
    endcase
    case ($urandom_range(3))
      0:       mx = 0;
      1:       mx = 16'hFFFF;
      2:       mx = $urandom_range(8192, 24576);
      default: mx = $urandom_range(16'hFFFF);
    endcase
    case ($urandom_range(4))
      0:       stp = 0;
      1:       stp = 24'hFFFFFF;
      2:       stp = $urandom_range(64536, 66536);
      3:       stp = $urandom_range(0, 262144);
      default: stp = $urandom_range(24'hFFFFFF);
    endcase
    case ($urandom_range(4))
      0:       tg = -1;
      1:       tg = 0;
      2:       tg = 65535;
      3:       tg = $urandom_range(1, 400);
      default: tg = -int'($urandom_range(2, 65536));
    endcase
    apply_settings(fb, mx, stp, tg);
  endtask

  task automatic send_random_item();
    logic signed [SAMPLE_W-1:0] smp;
    logic [DIST_W-1:0] fdist;
    if ($urandom_range(99) < 12) begin
      case ($urandom_range(3))
        0:       fdist = 16'd0;
        1:       fdist = 16'hFFFF;
        2:       fdist = DIST_W'($urandom_range(1, 2000));
        default: fdist = DIST_W'($urandom_range(16'hFFFF));
      endcase
      send_force(fdist);
    end else begin
      case ($urandom_range(15))
        0:       smp = SAMPLE_W'(SAMPLE_MAX);
        1:       smp = SAMPLE_W'(SAMPLE_MIN);
        2:       smp = '0;
        3:       smp = -24'sd1;
        default: smp = 24'($urandom);
      endcase
      send_audio(smp);
    end
  endtask

  // Reset defaults: the read position starts at the bottom of an empty store.
  task automatic test_reset_state();
    send_audio(SAMPLE_W'(SAMPLE_MAX));
    send_audio(SAMPLE_W'(SAMPLE_MIN));
    send_audio('0);
    send_audio(-24'sd1);
    send_force(16'd1);
    send_audio(24'sd1000);
    send_audio(-24'sd1000);
    wait_drained();
  endtask

  // Force to zero distance, and to the largest distance so that the position wraps up.
  task automatic test_force_limits();
    send_force(16'd0);
    send_audio(24'sd4096);
    send_force(16'hFFFF);
    send_audio(24'sd77);
    send_audio(-24'sd77);
    wait_drained();
  endtask

  // Largest gains drive both the feedback sum and the wet output into saturation.
  task automatic test_saturation();
    apply_settings(16'hFFFF, 16'hFFFF, 24'd65536, -1);
    send_force(16'd1);
    send_audio(SAMPLE_W'(SAMPLE_MAX));
    send_audio(SAMPLE_W'(SAMPLE_MAX));
    send_audio(SAMPLE_W'(SAMPLE_MIN));
    send_audio(SAMPLE_W'(SAMPLE_MIN));
    wait_drained();
  endtask

  // A huge step pulls read onto write; the target delay then holds it back.
  task automatic test_target_hold();
    apply_settings(0, 16384, 24'hFFFFFF, 3);
    send_audio(24'sd12345);
    send_audio(-24'sd54321);
    wait_drained();
    apply_settings(16384, 8192, 0, 65535);
    send_audio(24'sd2222);
    send_audio(-24'sd3333);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int segments, input int per_segment);
    for (int s = 0; s < segments; s++) begin
      apply_random_settings();
      repeat (per_segment) send_random_item();
      wait_drained();
    end
  endtask

  // The receiver holds off long enough for the block to fill and refuse transfers.
  task automatic test_output_stall();
    apply_settings(16384, 16384, 24'd65536, -1);
    stall_left = 400;
    repeat (40) send_audio(24'($urandom));
    wait_drained();
  endtask

  initial begin
    foreach (echo_mem[i]) echo_mem[i] = '0;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    cmd_i            = CMD_AUDIO;
    sample_in_i      = '0;
    force_distance_i = '0;
    out_ready_i      = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 11;
    recv_idle_pct = 62;
    test_reset_state();
    test_force_limits();
    test_saturation();
    test_target_hold();
    test_random_traffic(6, 95);

    send_idle_pct = 62;
    recv_idle_pct = 11;
    test_random_traffic(6, 95);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(6, 95);
    test_output_stall();

    if (wet_expected.size() != 0) begin
      $error("wet_out: %0d expected results never arrived", wet_expected.size());
      fail_count++;
    end
    $display("Sent %0d items (%0d force commands) and checked %0d wet samples,",
             items_sent, forces_sent, wet_checked);
    $display("across %0d register settings and three idling patterns; %0d mismatches.",
             settings_written, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/vsed_pkg.sv
design/vsed_ram.sv
design/vsed_ptr.sv
design/variable_speed_echo_delay.sv
test/tb.sv
